// File: hw/rtl/stp_pkg.sv
// shared types, constants and op codes of the short-term plasticity block
`default_nettype none
package stp_pkg;

	localparam int VAL_W   = 17;
	localparam int FB      = 16;
	localparam int TIME_W  = 48;
	localparam int TAU_W   = 16;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 2;
	localparam int QUO_W   = 29;
	localparam int E_W     = 33;
	localparam int P_W     = 66;
	localparam int CNT_W   = 5;
	localparam int OP_W    = 5;
	localparam int EXP_STEPS = 27;

	localparam logic [VAL_W-1:0] FX_ONE = 17'h10000;
	localparam logic [E_W-1:0] E_ONE = 33'h1_0000_0000;
	localparam logic [E_W-1:0] RECIP5 = 33'h0_CCCC_CCCD;
	localparam logic [E_W-1:0] RECIP3 = 33'h0_AAAA_AAAB;

	localparam logic [KIND_W-1:0] KIND_DECAY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPIKE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

	localparam logic [IDX_W-1:0] REG_BASE_USE = 2'd0;
	localparam logic [IDX_W-1:0] REG_TAU_D    = 2'd1;
	localparam logic [IDX_W-1:0] REG_TAU_F    = 2'd2;

	localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
	localparam logic [OP_W-1:0] OP_GAP       = 5'd2;
	localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd3;
	localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL_S_R5  = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL_S_E   = 5'd6;
	localparam logic [OP_W-1:0] OP_MUL_P_R3  = 5'd7;
	localparam logic [OP_W-1:0] OP_MUL_E_E   = 5'd8;
	localparam logic [OP_W-1:0] OP_E_SUB34   = 5'd9;
	localparam logic [OP_W-1:0] OP_E_SUB33   = 5'd10;
	localparam logic [OP_W-1:0] OP_E_SUB32   = 5'd11;
	localparam logic [OP_W-1:0] OP_E_SQ      = 5'd12;
	localparam logic [OP_W-1:0] OP_STORE     = 5'd13;
	localparam logic [OP_W-1:0] OP_DECAY_UPD = 5'd14;
	localparam logic [OP_W-1:0] OP_SPIKE_U   = 5'd15;
	localparam logic [OP_W-1:0] OP_SPIKE_X   = 5'd16;
	localparam logic [OP_W-1:0] OP_RESET_ST  = 5'd17;
	localparam logic [OP_W-1:0] OP_OUT       = 5'd18;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            sel_f;
	} stp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              gap_zero;
		logic              out_busy;
	} stp_status_t;

	// series then eight squarings of the exponential
	function automatic logic [OP_W-1:0] exp_op(input logic [CNT_W-1:0] step);
		logic [OP_W-1:0] op;
		op = OP_NONE;
		case (step)
			5'd0:  op = OP_MUL_S_R5;
			5'd1:  op = OP_E_SUB34;
			5'd2:  op = OP_MUL_S_E;
			5'd3:  op = OP_E_SUB34;
			5'd4:  op = OP_MUL_S_E;
			5'd5:  op = OP_MUL_P_R3;
			5'd6:  op = OP_E_SUB33;
			5'd7:  op = OP_MUL_S_E;
			5'd8:  op = OP_E_SUB33;
			5'd9:  op = OP_MUL_S_E;
			5'd10: op = OP_E_SUB32;
			default: op = step[0] ? OP_MUL_E_E : OP_E_SQ;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stp_if.sv
// valid/ready channel interfaces for events and results
`default_nettype none
interface stp_event_if;
	logic                          valid;
	logic                          ready;
	logic [stp_pkg::KIND_W-1:0]    kind;
	logic [stp_pkg::TIME_W-1:0]    event_time;
	modport source (output valid, kind, event_time, input ready);
	modport sink (input valid, kind, event_time, output ready);
endinterface

interface stp_result_if;
	logic                        valid;
	logic                        ready;
	logic [stp_pkg::VAL_W-1:0]   resource_level;
	logic [stp_pkg::VAL_W-1:0]   use_level;
	logic [stp_pkg::VAL_W-1:0]   modulation;
	modport source (output valid, resource_level, use_level, modulation, input ready);
	modport sink (input valid, resource_level, use_level, modulation, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/stp_ctrl.sv
// sequencing state machine of the plasticity block
`default_nettype none
module stp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire stp_pkg::stp_status_t sts,
	output stp_pkg::stp_cmd_t         cmd
);
	import stp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_GAP   = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_DINIT = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_EXP   = 4'd5;
	localparam logic [3:0] S_STORE = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_SPU   = 4'd8;
	localparam logic [3:0] S_SPX   = 4'd9;
	localparam logic [3:0] S_RST   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             self_q, self_nxt;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt = cnt_q;
		self_nxt = self_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.sel_f = self_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_nxt = S_GAP;
				end
			end
			S_GAP: begin
				cmd.op = OP_GAP;
				state_nxt = S_CHK;
			end
			S_CHK: begin
				case (sts.kind) inside
					KIND_RESET: state_nxt = S_RST;
					KIND_DECAY, KIND_SPIKE: begin
						if (sts.gap_zero) begin
							state_nxt = (sts.kind == KIND_SPIKE) ? S_SPU : S_OUT;
						end else begin
							self_nxt = 1'b0;
							state_nxt = S_DINIT;
						end
					end
					default: state_nxt = S_OUT;
				endcase
			end
			S_DINIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_nxt = '0;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					cnt_nxt = '0;
					state_nxt = S_EXP;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			S_EXP: begin
				cmd.op = exp_op(cnt_q);
				if (cnt_q == CNT_W'(EXP_STEPS - 1)) begin
					cnt_nxt = '0;
					state_nxt = S_STORE;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			S_STORE: begin
				cmd.op = OP_STORE;
				if (self_q) begin
					state_nxt = S_UPD;
				end else begin
					self_nxt = 1'b1;
					state_nxt = S_DINIT;
				end
			end
			S_UPD: begin
				cmd.op = OP_DECAY_UPD;
				state_nxt = (sts.kind == KIND_SPIKE) ? S_SPU : S_OUT;
			end
			S_SPU: begin
				cmd.op = OP_SPIKE_U;
				state_nxt = S_SPX;
			end
			S_SPX: begin
				cmd.op = OP_SPIKE_X;
				state_nxt = S_OUT;
			end
			S_RST: begin
				cmd.op = OP_RESET_ST;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.op = OP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			self_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q <= cnt_nxt;
			self_q <= self_nxt;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/stp_datapath.sv
// state, divider, exponential unit and update arithmetic
`default_nettype none
module stp_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stp_pkg::stp_cmd_t             cmd,
	output stp_pkg::stp_status_t               sts,
	input  wire logic [stp_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [stp_pkg::TIME_W-1:0]    in_time,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [stp_pkg::VAL_W-1:0]          out_resource,
	output logic [stp_pkg::VAL_W-1:0]          out_use,
	output logic [stp_pkg::VAL_W-1:0]          out_mod,
	input  wire logic                          wr_en,
	input  wire logic [stp_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [stp_pkg::VAL_W-1:0]     wr_data
);
	import stp_pkg::*;

	logic [VAL_W-1:0]  base_q;
	logic [TAU_W-1:0]  tau_d_q, tau_f_q;
	logic [VAL_W-1:0]  x_q, u_q;
	logic [TIME_W-1:0] last_q, time_q, gap_q;
	logic [KIND_W-1:0] kind_q;
	logic [TAU_W-1:0]  tau_q, rem_q;
	logic [QUO_W-1:0]  dvd_q, quo_q;
	logic              zero_q;
	logic [E_W-1:0]    e_q;
	logic [P_W-1:0]    prod_q;
	logic [VAL_W-1:0]  dd_q, df_q;
	logic              out_valid_q;

	logic [VAL_W-1:0]   ub;
	logic [TAU_W-1:0]   tau_sel;
	logic [20:0]        limit;
	logic [TAU_W:0]     trial, trial_diff;
	logic               trial_ge;
	logic [E_W-1:0]     mul_a, mul_b;
	logic [E_W:0]       e_round;
	logic [VAL_W-1:0]   factor;
	logic [2*VAL_W-1:0] x_prod, u_prod, du_prod, sx_prod, m_prod;
	logic [VAL_W-1:0]   u_diff;
	logic               u_ge;
	logic [VAL_W:0]     u_sum;

	assign ub = (base_q > FX_ONE) ? FX_ONE : base_q;
	assign tau_sel = cmd.sel_f ? tau_f_q : tau_d_q;
	assign limit = {1'b0, tau_sel, 4'b0} + {3'b0, tau_sel, 2'b0};

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign trial_ge = trial >= {1'b0, tau_q};
	assign trial_diff = trial - {1'b0, tau_q};

	always_comb begin
		mul_a = {4'b0, quo_q};
		mul_b = e_q;
		case (cmd.op)
			OP_MUL_S_R5: mul_b = RECIP5;
			OP_MUL_P_R3: begin
				mul_a = {1'b0, prod_q[63:32]};
				mul_b = RECIP3;
			end
			OP_MUL_E_E: mul_a = e_q;
			default: ;
		endcase
	end

	assign e_round = {1'b0, e_q} + (E_W+1)'(1 << (FB - 1));
	assign factor = zero_q ? '0 : e_round[32:16];

	assign u_ge = u_q >= ub;
	assign u_diff = u_ge ? (u_q - ub) : (ub - u_q);
	assign x_prod = (FX_ONE - x_q) * dd_q;
	assign u_prod = u_diff * df_q;
	assign du_prod = ub * (FX_ONE - u_q);
	assign u_sum = {1'b0, u_q} + {1'b0, du_prod[32:16]};
	assign sx_prod = x_q * (FX_ONE - u_q);
	assign m_prod = u_q * x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 17'd32768;
			tau_d_q <= 16'd800;
			tau_f_q <= 16'd50;
			x_q <= FX_ONE;
			u_q <= 17'd32768;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_BASE_USE: base_q <= wr_data;
					REG_TAU_D: tau_d_q <= wr_data[TAU_W-1:0];
					REG_TAU_F: tau_f_q <= wr_data[TAU_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_DECAY_UPD: begin
					x_q <= FX_ONE - x_prod[32:16];
					u_q <= u_ge ? (ub + u_prod[32:16]) : (ub - u_prod[32:16]);
					last_q <= time_q;
				end
				OP_SPIKE_U: u_q <= (u_sum > {1'b0, FX_ONE}) ? FX_ONE : u_sum[VAL_W-1:0];
				OP_SPIKE_X: x_q <= sx_prod[32:16];
				OP_RESET_ST: begin
					x_q <= FX_ONE;
					u_q <= ub;
					last_q <= time_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op) inside
			OP_LOAD: begin
				kind_q <= in_kind;
				time_q <= in_time;
			end
			OP_GAP: gap_q <= time_q - last_q;
			OP_DIV_INIT: begin
				tau_q <= tau_sel;
				zero_q <= (tau_sel == '0) || (gap_q > {27'b0, limit});
				rem_q <= gap_q[20:5];
				dvd_q <= {gap_q[4:0], 24'b0};
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_diff[TAU_W-1:0] : trial[TAU_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], trial_ge};
				dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			end
			OP_MUL_S_R5, OP_MUL_S_E, OP_MUL_P_R3, OP_MUL_E_E: prod_q <= mul_a * mul_b;
			OP_E_SUB34: e_q <= E_ONE - {1'b0, prod_q[65:34]};
			OP_E_SUB33: e_q <= E_ONE - prod_q[65:33];
			OP_E_SUB32: e_q <= E_ONE - prod_q[64:32];
			OP_E_SQ: e_q <= prod_q[64:32];
			OP_STORE: begin
				if (cmd.sel_f) begin
					df_q <= factor;
				end else begin
					dd_q <= factor;
				end
			end
			OP_OUT: begin
				out_resource <= x_q;
				out_use <= u_q;
				out_mod <= m_prod[32:16];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sts.kind = kind_q;
	assign sts.gap_zero = (gap_q == '0);
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule
`default_nettype wire

// File: hw/rtl/short_term_synapse_plasticity.sv
// each decay factor is computed by setup, a 29-step restoring divide, 27 steps around one
// shared 33x33 multiplier and a store; the two time constants run one after the other
// events are handled one at a time; the next event is taken while a result
// waits, and the following result stalls until that one is transferred
// reset: x = 1.0, u = 0.5, last time 0, registers at their defaults, no result pending
`default_nettype none
module short_term_synapse_plasticity (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	stp_event_if.sink                      events,
	stp_result_if.source                   results,
	input  wire logic                      wr_en,
	input  wire logic [stp_pkg::IDX_W-1:0] wr_index,
	input  wire logic [stp_pkg::VAL_W-1:0] wr_data
);
	import stp_pkg::*;

	stp_cmd_t    cmd;
	stp_status_t sts;

	stp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (events.valid),
		.in_ready (events.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_kind      (events.kind),
		.in_time      (events.event_time),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.out_resource (results.resource_level),
		.out_use      (results.use_level),
		.out_mod      (results.modulation),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

endmodule
`default_nettype wire

// File: hw/rtl/stp_checker.sv
// port-level checks of the plasticity block and their binding
`default_nettype none
module stp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [stp_pkg::VAL_W-1:0] resource_level,
	input wire logic [stp_pkg::VAL_W-1:0] use_level
);
	import stp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("event taken while another is in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (resource_level <= FX_ONE) && (use_level <= FX_ONE))
		else $error("level above one");

endmodule

bind short_term_synapse_plasticity stp_checker u_stp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (events.valid),
	.in_ready       (events.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.resource_level (results.resource_level),
	.use_level      (results.use_level)
);
`default_nettype wire
